// ----- rtl/core/sukt_pkg.sv -----
// Shared types, field widths and codes for the sorted unique key table.
`timescale 1ns / 1ps

package sukt_pkg;

  // Default table depth
  localparam int DEPTH_DEFAULT = 64;

  // Item field widths
  localparam int FUNC_W = 2;
  localparam int KEY_W  = 16;
  localparam int PL_W   = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;

  // Stored entry: payload above key
  localparam int ENTRY_W = KEY_W + PL_W;

  // Stream data widths, padded to whole bytes
  localparam int IN_W  = ((FUNC_W + 2 * KEY_W + PL_W + 7) / 8) * 8;
  localparam int OUT_W = ((STAT_W + POS_W + PL_W + CNT_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 2'd0,
    FN_DELETE  = 2'd1,
    FN_LOOKUP  = 2'd2,
    FN_REPLACE = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

// ----- rtl/core/sukt_store.sv -----
// Entry memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module sukt_store #(
  parameter int DEPTH = sukt_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(DEPTH)-1:0]          waddr,
  input  logic [sukt_pkg::ENTRY_W-1:0]      wdata,
  input  logic [$clog2(DEPTH)-1:0]          raddr,
  output logic [sukt_pkg::ENTRY_W-1:0]      rdata
);

  logic [sukt_pkg::ENTRY_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sorted_unique_key_table_unit.sv -----
// Top level of the sorted unique key table: sequencer around the entry memory.
`timescale 1ns / 1ps

// Keeps up to DEPTH records in ascending order of unique 16-bit key, each with a
// 32-bit payload, in one memory of DEPTH entries. One item is worked at a time.
// After the accepting cycle the stored entries are scanned, one memory read per
// cycle (an empty table skips the scan), and then a decision is made. A lookup
// that hits does one more memory read. Insert, delete and replace then move the
// entries between the old and the new place one step each, one copy per cycle
// through the single read and single write port, followed by the write of the new
// entry for insert and replace. The result is then handed to the output register
// once the previous result has left it. The memory needs no clearing after reset;
// the block takes an item as soon as it comes out of reset. The input is taken again
// while a result still waits at the output.

module sorted_unique_key_table_unit #(
  parameter int DEPTH = sukt_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // s_tdata: func[1:0], key[17:2], new_key[33:18], payload[65:34], zero pad
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sukt_pkg::IN_W-1:0]   s_tdata,
  // m_tdata: status[1:0], position[7:2], found_payload[39:8], entry_count[46:40], pad
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sukt_pkg::OUT_W-1:0]  m_tdata
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PXW = AW + sukt_pkg::POS_W;
  localparam int CXW = CW + sukt_pkg::CNT_W;
  localparam int KW  = sukt_pkg::KEY_W;
  localparam int PW  = sukt_pkg::PL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DECIDE,
    S_LOOK,
    S_MOVE,
    S_FINAL,
    S_DONE
  } state_t;

  state_t state;

  // Latched item
  sukt_pkg::func_t   func;
  logic [KW-1:0]     key;
  logic [KW-1:0]     new_key;
  logic [PW-1:0]     payload;

  // Table fill and scan results
  logic [CW-1:0]     occ;
  logic [AW-1:0]     idx;
  logic              rv;
  logic [AW-1:0]     ri;
  logic              found_k;
  logic [AW-1:0]     at;
  logic              found_nk;
  logic [AW-1:0]     other;
  logic [CW-1:0]     lt_cnt;

  // Move control
  logic              mv_up;
  logic [CW-1:0]     mv_cnt;
  logic              cp_v;
  logic [AW-1:0]     cp_dst;
  logic              fin_we;
  logic [AW-1:0]     fin_addr;
  logic [KW-1:0]     fin_key;

  // Result
  sukt_pkg::status_t res_status;
  logic [AW-1:0]     res_pos;
  logic [PW-1:0]     res_fpl;

  // Memory ports
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [sukt_pkg::ENTRY_W-1:0]  mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [sukt_pkg::ENTRY_W-1:0]  mem_rdata;

  // Helper values
  logic [KW-1:0]     rd_key;
  logic [KW-1:0]     target;
  logic [CW-1:0]     at_ext;
  logic [CW-1:0]     occ_m1;
  logic              last_scan;
  logic              full;
  logic [PXW-1:0]    pos_ext;
  logic [CXW-1:0]    cnt_ext;

  sukt_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign s_tready  = (state == S_IDLE);

  assign rd_key    = mem_rdata[KW-1:0];
  assign target    = (func == sukt_pkg::FN_REPLACE) ? new_key : key;
  assign at_ext    = CW'(at);
  assign occ_m1    = occ - CW'(1);
  assign last_scan = (CW'(idx) + CW'(1)) == occ;
  assign full      = (occ == CW'(DEPTH));
  assign pos_ext   = PXW'(res_pos);
  assign cnt_ext   = CXW'(occ);

  // Read address: lookup fetch in the decision cycle, else the walking index
  assign mem_raddr = (state == S_DECIDE) ? at : idx;

  // Write port: pending copy first, then the new entry
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cp_dst;
    mem_wdata = mem_rdata;
    if (cp_v) begin
      mem_we = 1'b1;
    end else if (state == S_FINAL && fin_we) begin
      mem_we    = 1'b1;
      mem_waddr = fin_addr;
      mem_wdata = {payload, fin_key};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occ      <= '0;
      rv       <= 1'b0;
      cp_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rv   <= (state == S_SCAN);
      // One copy issued per move cycle while copies remain; the write lands in the cycle after
      cp_v <= (state == S_MOVE) && (mv_cnt != '0);

      // Scan compare on returned entry
      if (rv) begin
        if (rd_key == key) begin
          found_k <= 1'b1;
          at      <= ri;
        end
        if (rd_key == new_key) begin
          found_nk <= 1'b1;
          other    <= ri;
        end
        if (rd_key < target && rd_key != key) begin
          lt_cnt <= lt_cnt + CW'(1);
        end
      end

      // Output register drains independently
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func     <= sukt_pkg::func_t'(s_tdata[1:0]);
            key      <= s_tdata[17:2];
            new_key  <= s_tdata[33:18];
            payload  <= s_tdata[65:34];
            found_k  <= 1'b0;
            found_nk <= 1'b0;
            lt_cnt   <= '0;
            idx      <= '0;
            res_fpl  <= '0;
            res_pos  <= '0;
            fin_we   <= 1'b0;
            mv_cnt   <= '0;
            state    <= (occ == '0) ? S_DECIDE : S_SCAN;
          end
        end

        S_SCAN: begin
          ri  <= idx;
          idx <= idx + AW'(1);
          if (last_scan) begin
            state <= S_WAIT;
          end
        end

        S_WAIT: begin
          state <= S_DECIDE;
        end

        S_DECIDE: begin
          unique case (func)
            sukt_pkg::FN_INSERT: begin
              if (found_k) begin
                res_status <= sukt_pkg::ST_DUPLICATE;
                res_pos    <= at;
                state      <= S_DONE;
              end else if (full) begin
                res_status <= sukt_pkg::ST_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= sukt_pkg::ST_OK;
                state      <= S_MOVE;
                mv_up      <= 1'b1;
                idx        <= occ_m1[AW-1:0];
                mv_cnt     <= occ - lt_cnt;
                fin_we     <= 1'b1;
                fin_addr   <= lt_cnt[AW-1:0];
                fin_key    <= key;
                res_pos    <= lt_cnt[AW-1:0];
                occ        <= occ + CW'(1);
              end
            end
            sukt_pkg::FN_DELETE: begin
              if (!found_k) begin
                res_status <= sukt_pkg::ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                res_status <= sukt_pkg::ST_OK;
                state      <= S_MOVE;
                mv_up      <= 1'b0;
                idx        <= at + AW'(1);
                mv_cnt     <= occ_m1 - at_ext;
                res_pos    <= at;
                occ        <= occ_m1;
              end
            end
            sukt_pkg::FN_LOOKUP: begin
              if (!found_k) begin
                res_status <= sukt_pkg::ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                res_status <= sukt_pkg::ST_OK;
                res_pos    <= at;
                state      <= S_LOOK;
              end
            end
            sukt_pkg::FN_REPLACE: begin
              if (!found_k) begin
                res_status <= sukt_pkg::ST_NOT_FOUND;
                state      <= S_DONE;
              end else if (new_key != key && found_nk) begin
                res_status <= sukt_pkg::ST_DUPLICATE;
                res_pos    <= other;
                state      <= S_DONE;
              end else begin
                res_status <= sukt_pkg::ST_OK;
                state      <= S_MOVE;
                fin_we     <= 1'b1;
                fin_key    <= new_key;
                if (new_key == key) begin
                  // same key: payload rewritten in place
                  fin_addr <= at;
                  res_pos  <= at;
                end else if (lt_cnt >= at_ext) begin
                  // new place above: close up toward the old slot
                  mv_up    <= 1'b0;
                  idx      <= at + AW'(1);
                  mv_cnt   <= lt_cnt - at_ext;
                  fin_addr <= lt_cnt[AW-1:0];
                  res_pos  <= lt_cnt[AW-1:0];
                end else begin
                  // new place below: open a gap there
                  mv_up    <= 1'b1;
                  idx      <= at - AW'(1);
                  mv_cnt   <= at_ext - lt_cnt;
                  fin_addr <= lt_cnt[AW-1:0];
                  res_pos  <= lt_cnt[AW-1:0];
                end
              end
            end
            default: begin
              res_status <= sukt_pkg::ST_OK;
              state      <= S_DONE;
            end
          endcase
        end

        S_LOOK: begin
          res_fpl <= mem_rdata[sukt_pkg::ENTRY_W-1:KW];
          state   <= S_DONE;
        end

        // Walk the copies; cp_v above issues the write of each
        S_MOVE: begin
          if (mv_cnt != '0) begin
            cp_dst <= mv_up ? (idx + AW'(1)) : (idx - AW'(1));
            idx    <= mv_up ? (idx - AW'(1)) : (idx + AW'(1));
            mv_cnt <= mv_cnt - CW'(1);
          end else begin
            state <= S_FINAL;
          end
        end

        S_FINAL: begin
          state <= S_DONE;
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(sukt_pkg::OUT_W - 47){1'b0}}, cnt_ext[6:0], res_fpl,
                         pos_ext[5:0], res_status};
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- test/tb_sorted_unique_key_table_unit.sv -----
// Testbench for the sorted unique key table: stream driver, result monitor and table predictor.
`timescale 1ns / 1ps

module tb_sorted_unique_key_table_unit;

  localparam int DEPTH      = 64;
  localparam int KEY_POOL   = 100;
  localparam int RAND_ITEMS = 2000;
  localparam int PHASE_LEN  = 250;
  localparam int QUIET_LO   = 900;
  localparam int QUIET_HI   = 1250;
  localparam int IDLE_PCT   = 26;
  localparam int TAIL_WAIT  = 2 * DEPTH + 40;
  localparam int CYCLE_LIMIT = 1500000;

  // One operation waiting to be sent
  typedef struct {
    sukt_pkg::func_t f;
    logic [15:0]     key;
    logic [15:0]     new_key;
    logic [31:0]     payload;
    bit              wait_drain;
  } table_op_t;

  // One result as the table should report it
  typedef struct {
    sukt_pkg::status_t status;
    logic [5:0]        position;
    logic [31:0]       found_payload;
    logic [6:0]        entry_count;
  } table_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [sukt_pkg::IN_W-1:0]   s_tdata = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [sukt_pkg::OUT_W-1:0]  m_tdata;

  table_op_t     op_queue[$];
  table_result_t result_queue[$];

  // Predicted table contents
  logic [15:0] tbl_key[DEPTH];
  logic [31:0] tbl_payload[DEPTH];
  int          tbl_count = 0;

  logic [15:0] key_pool[KEY_POOL];
  int          n_sent = 0;
  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          cycle_count = 0;
  int          func_count[4];
  int          status_count[4];

  sorted_unique_key_table_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter with run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               result_queue.size());
      $display("sorted_unique_key_table_unit regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("%0t ns result %0d: %s expected 0x%0h got 0x%0h", $time, n_checked, what,
             want, got);
    n_errors++;
  endtask

  // Predictor: search, shift and place entries like the table does
  function automatic int find_slot(logic [15:0] k);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int p);
    for (int i = p; i + 1 < tbl_count; i++) begin
      tbl_key[i]     = tbl_key[i + 1];
      tbl_payload[i] = tbl_payload[i + 1];
    end
    tbl_count--;
  endfunction

  function automatic int place_sorted(logic [15:0] k, logic [31:0] pl);
    int p;
    p = 0;
    while (p < tbl_count && tbl_key[p] < k) p++;
    for (int i = tbl_count; i > p; i--) begin
      tbl_key[i]     = tbl_key[i - 1];
      tbl_payload[i] = tbl_payload[i - 1];
    end
    tbl_key[p]     = k;
    tbl_payload[p] = pl;
    tbl_count++;
    return p;
  endfunction

  function automatic table_result_t run_table_op(sukt_pkg::func_t f, logic [15:0] k,
                                                 logic [15:0] nk, logic [31:0] pl);
    table_result_t r;
    int at;
    int other;
    r.status        = sukt_pkg::ST_OK;
    r.position      = '0;
    r.found_payload = '0;
    at = find_slot(k);
    case (f)
      sukt_pkg::FN_INSERT: begin
        if (at >= 0) begin
          r.status   = sukt_pkg::ST_DUPLICATE;
          r.position = 6'(at);
        end else if (tbl_count >= DEPTH) begin
          r.status = sukt_pkg::ST_FULL;
        end else begin
          r.position = 6'(place_sorted(k, pl));
        end
      end
      sukt_pkg::FN_DELETE: begin
        if (at >= 0) begin
          drop_slot(at);
          r.position = 6'(at);
        end else begin
          r.status = sukt_pkg::ST_NOT_FOUND;
        end
      end
      sukt_pkg::FN_LOOKUP: begin
        if (at >= 0) begin
          r.position      = 6'(at);
          r.found_payload = tbl_payload[at];
        end else begin
          r.status = sukt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        other = (nk != k) ? find_slot(nk) : -1;
        if (at < 0) begin
          r.status = sukt_pkg::ST_NOT_FOUND;
        end else if (other >= 0) begin
          r.status   = sukt_pkg::ST_DUPLICATE;
          r.position = 6'(other);
        end else begin
          drop_slot(at);
          r.position = 6'(place_sorted(nk, pl));
        end
      end
    endcase
    r.entry_count = 7'(tbl_count);
    return r;
  endfunction

  // Input side: predict each accepted item; output side: check each result
  always @(posedge clk) begin : monitor
    table_result_t   want;
    sukt_pkg::func_t f;
    if (!rst && s_tvalid && s_tready) begin
      f = sukt_pkg::func_t'(s_tdata[1:0]);
      result_queue.push_back(run_table_op(f, s_tdata[17:2], s_tdata[33:18], s_tdata[65:34]));
      func_count[f]++;
      n_accepted <= n_accepted + 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (result_queue.size() == 0) begin
        report_mismatch("result with none expected, data", 0, m_tdata);
      end else begin
        want = result_queue.pop_front();
        status_count[want.status]++;
        if (m_tdata[1:0] != want.status)
          report_mismatch("status", want.status, m_tdata[1:0]);
        if (m_tdata[7:2] != want.position)
          report_mismatch("position", want.position, m_tdata[7:2]);
        if (m_tdata[39:8] != want.found_payload)
          report_mismatch("found_payload", want.found_payload, m_tdata[39:8]);
        if (m_tdata[46:40] != want.entry_count)
          report_mismatch("entry_count", want.entry_count, m_tdata[46:40]);
      end
      n_checked++;
    end
  end

  function automatic bit quiet_window();
    return n_accepted >= QUIET_LO && n_accepted < QUIET_HI;
  endfunction

  // Sender: one item at a time from the op queue, random gaps outside the quiet window
  always @(negedge clk) begin : driver
    table_op_t op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && n_accepted < n_sent) begin
      s_tvalid <= 1'b1;
    end else if (op_queue.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (op_queue[0].wait_drain && result_queue.size() != 0) begin
      s_tvalid <= 1'b0;
    end else if (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
    end else begin
      op = op_queue.pop_front();
      s_tdata  <= {6'b0, op.payload, op.new_key, op.key, op.f};
      s_tvalid <= 1'b1;
      n_sent++;
    end
  end

  // Receiver: random back-pressure outside the quiet window
  always @(negedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= quiet_window() || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic add_op(sukt_pkg::func_t f, logic [15:0] k, logic [15:0] nk, logic [31:0] pl,
                        bit drain = 1'b0);
    table_op_t op;
    op.f          = f;
    op.key        = k;
    op.new_key    = nk;
    op.payload    = pl;
    op.wait_drain = drain;
    op_queue.push_back(op);
  endtask

  // Mostly keys from a small pool so that hits, duplicates and a full table occur
  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 99) < 88) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  // Operation mix per phase: fill, churn, drain
  function automatic sukt_pkg::func_t pick_func(int phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      0:       return r < 70 ? sukt_pkg::FN_INSERT : r < 80 ? sukt_pkg::FN_DELETE :
                      r < 90 ? sukt_pkg::FN_LOOKUP : sukt_pkg::FN_REPLACE;
      1:       return sukt_pkg::func_t'(r % 4);
      default: return r < 20 ? sukt_pkg::FN_INSERT : r < 70 ? sukt_pkg::FN_DELETE :
                      r < 85 ? sukt_pkg::FN_LOOKUP : sukt_pkg::FN_REPLACE;
    endcase
  endfunction

  initial begin : stimulus
    sukt_pkg::func_t f;
    logic [15:0]     k;
    logic [15:0]     nk;
    int              phase;
    int              r;

    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = 16'($urandom_range(0, 65535));
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'h8000;

    // Directed: empty table, extremes, duplicates, replace moves and collisions
    add_op(sukt_pkg::FN_LOOKUP,  16'h0000, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_DELETE,  16'hFFFF, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_REPLACE, 16'h8000, 16'h0001, 32'h1234_5678);
    add_op(sukt_pkg::FN_INSERT,  16'h8000, 16'h0000, 32'hA5A5_A5A5);
    add_op(sukt_pkg::FN_INSERT,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_op(sukt_pkg::FN_INSERT,  16'h0000, 16'hFFFF, 32'h0000_0000);
    add_op(sukt_pkg::FN_INSERT,  16'h8000, 16'h0000, 32'h5A5A_5A5A);
    add_op(sukt_pkg::FN_LOOKUP,  16'hFFFF, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_LOOKUP,  16'h0000, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_LOOKUP,  16'h8000, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_REPLACE, 16'h8000, 16'h8000, 32'hDEAD_BEEF);
    add_op(sukt_pkg::FN_LOOKUP,  16'h8000, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_REPLACE, 16'h8000, 16'h0000, 32'h0BAD_F00D);
    add_op(sukt_pkg::FN_REPLACE, 16'h8000, 16'h0001, 32'h0000_0001);
    add_op(sukt_pkg::FN_REPLACE, 16'hFFFF, 16'h0002, 32'h8000_0000);
    add_op(sukt_pkg::FN_REPLACE, 16'h0000, 16'hFFFE, 32'h7FFF_FFFF);
    add_op(sukt_pkg::FN_LOOKUP,  16'hFFFE, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_REPLACE, 16'h1234, 16'h4321, 32'h0000_0000);
    add_op(sukt_pkg::FN_DELETE,  16'h0001, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_DELETE,  16'h0001, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_DELETE,  16'hFFFE, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_LOOKUP,  16'h0002, 16'hFFFF, 32'hFFFF_FFFF);
    add_op(sukt_pkg::FN_DELETE,  16'h0002, 16'h0000, 32'h0000_0000);
    add_op(sukt_pkg::FN_LOOKUP,  16'h0002, 16'h0000, 32'h0000_0000, 1'b1);

    // Random: phases that fill the table past full, churn it and drain it
    for (int i = 0; i < RAND_ITEMS; i++) begin
      phase = (i / PHASE_LEN) % 3;
      f = pick_func(phase);
      k = pick_key();
      r = $urandom_range(0, 99);
      nk = r < 15 ? k : r < 85 ? pick_key() : 16'($urandom_range(0, 65535));
      add_op(f, k, nk, 32'($urandom()), (i % PHASE_LEN == 0) || (i == RAND_ITEMS / 2));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (op_queue.size() != 0 || n_accepted < n_sent || result_queue.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("%0d operations (insert %0d, delete %0d, lookup %0d, replace %0d) checked",
             n_accepted, func_count[sukt_pkg::FN_INSERT], func_count[sukt_pkg::FN_DELETE],
             func_count[sukt_pkg::FN_LOOKUP], func_count[sukt_pkg::FN_REPLACE]);
    $display("outcomes: ok %0d, not found %0d, duplicate %0d, table full %0d; %0d errors",
             status_count[sukt_pkg::ST_OK], status_count[sukt_pkg::ST_NOT_FOUND],
             status_count[sukt_pkg::ST_DUPLICATE], status_count[sukt_pkg::ST_FULL],
             n_errors);
    if (n_errors == 0)
      $display("sorted_unique_key_table_unit regression: pass");
    else
      $display("sorted_unique_key_table_unit regression: fail");
    $finish;
  end

endmodule
